// File: rtl/core/pscm_pkg.sv
// shared types, register indexes and command constants for the steering mode controller
package pscm_pkg;

  localparam int DIST_W = 16;
  localparam int DIST_BITS_DEF = 16;
  localparam int CFG_NUM = 8;
  localparam int CFG_IDX_W = 3;
  localparam int FRAME_W = 32;
  localparam int STEER_W = 16;
  localparam int SPEED_W = 9;
  localparam int GAIN_W = 15;

  localparam logic [GAIN_W-1:0] STEER_GAIN = 15'd19421;

  localparam logic signed [STEER_W-1:0] STEER_GEST_LEFT  = -16'sd600;
  localparam logic signed [STEER_W-1:0] STEER_GEST_RIGHT = 16'sd700;
  localparam logic signed [STEER_W-1:0] STEER_NUDGE      = 16'sd10;
  localparam logic signed [STEER_W-1:0] STEER_ZERO       = 16'sd0;
  localparam logic signed [STEER_W-1:0] STEER_UTURN_FWD  = 16'sd600;
  localparam logic signed [STEER_W-1:0] STEER_UTURN_REV  = -16'sd700;
  localparam logic signed [STEER_W-1:0] STEER_FINISH     = 16'sd100;

  localparam logic signed [SPEED_W-1:0] SPEED_TURN    = 9'sd120;
  localparam logic signed [SPEED_W-1:0] SPEED_BACK    = -9'sd120;
  localparam logic signed [SPEED_W-1:0] SPEED_STOP    = 9'sd0;
  localparam logic signed [SPEED_W-1:0] SPEED_FINAL   = 9'sd130;
  localparam logic signed [SPEED_W-1:0] SPEED_FWD     = 9'sd140;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX     = 9'sd180;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_FRAMES    = 3'd0,
    CFG_FRONT_CLEAR    = 3'd1,
    CFG_NEAR_WALL      = 3'd2,
    CFG_REOPEN         = 3'd3,
    CFG_FOOT_BACK      = 3'd4,
    CFG_FOOT_STOP      = 3'd5,
    CFG_SIDE_LIMIT     = 3'd6,
    CFG_WALL_TARGET    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_LEFT  = 2'd1,
    GEST_RIGHT = 2'd2
  } gesture_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FWD   = 2'd1,
    PH_REV   = 2'd2,
    PH_FINAL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [DIST_W-1:0] turn_frames;
    logic [DIST_W-1:0] front_clear_mm;
    logic [DIST_W-1:0] near_wall_mm;
    logic [DIST_W-1:0] reopen_mm;
    logic [DIST_W-1:0] foot_back_mm;
    logic [DIST_W-1:0] foot_stop_mm;
    logic [DIST_W-1:0] side_limit_mm;
    logic [DIST_W-1:0] wall_target_mm;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] front_mm;
    logic [DIST_W-1:0] foot_mm;
    logic [DIST_W-1:0] side_a_mm;
    logic [DIST_W-1:0] side_b_mm;
    logic              person_seen;
    logic [1:0]        pose_turn;
    logic              friend_color;
  } frame_t;

  typedef struct packed {
    logic [FRAME_W-1:0]        frame_count;
    logic [FRAME_W-1:0]        turn_start;
    logic                      patrol_turning;
    phase_t                    uturn_phase;
    logic                      lost_rearm;
    gesture_t                  gesture_turn;
    logic signed [STEER_W-1:0] steer_hold;
    logic signed [SPEED_W-1:0] speed_hold;
  } state_t;

endpackage

// File: rtl/core/patrol_steering_mode_controller_unit.sv
// top level of the patrol steering mode controller: registers, handshakes and config
//
//  channel | signals                          | direction | moves
//  in      | in_valid / in_ready + 7 fields   | to block  | one sensor frame per transaction
//  out     | out_valid / out_ready + 2 fields | from block| one steer/speed command
//  cfg     | cfg_we, cfg_index, cfg_data      | to block  | one register write, no wait
//
// a frame is decided by combinational logic while it sits in the input register;
// its command and the new state load into the output and state registers once the
// output register is free. one frame per cycle sustained while the output is not stalled.
// the only limit is the output register: a stalled command stalls the input stage.
// rst is synchronous; it clears the frame state and restores register defaults.
module patrol_steering_mode_controller_unit #(
  parameter int DIST_BITS = pscm_pkg::DIST_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [pscm_pkg::DIST_W-1:0]             front_mm,
  input  logic [pscm_pkg::DIST_W-1:0]             foot_mm,
  input  logic [pscm_pkg::DIST_W-1:0]             side_a_mm,
  input  logic [pscm_pkg::DIST_W-1:0]             side_b_mm,
  input  logic                                    person_seen,
  input  logic [1:0]                              pose_turn,
  input  logic                                    friend_color,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pscm_pkg::STEER_W-1:0]     steer_cmd,
  output logic signed [pscm_pkg::SPEED_W-1:0]     speed_cmd,
  input  logic                                    cfg_we,
  input  logic [pscm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pscm_pkg::DIST_W-1:0]             cfg_data
);

  localparam int DIST_USED = (DIST_BITS < pscm_pkg::DIST_W) ? DIST_BITS : pscm_pkg::DIST_W;
  localparam logic [pscm_pkg::DIST_W-1:0] DIST_MASK =
    {pscm_pkg::DIST_W{1'b1}} >> (pscm_pkg::DIST_W - DIST_USED);

  pscm_pkg::cfg_t   cfg;
  pscm_pkg::frame_t frame;
  pscm_pkg::state_t st;
  pscm_pkg::state_t st_next;
  logic             frame_valid;
  logic             out_load;
  logic             frame_adv;

  assign out_load  = !out_valid || out_ready;
  assign frame_adv = frame_valid && out_load;
  assign in_ready  = !frame_valid || out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_frames    <= 16'd120;
      cfg.front_clear_mm <= 16'd3000;
      cfg.near_wall_mm   <= 16'd600;
      cfg.reopen_mm      <= 16'd1700;
      cfg.foot_back_mm   <= 16'd3000;
      cfg.foot_stop_mm   <= 16'd3200;
      cfg.side_limit_mm  <= 16'd2000;
      cfg.wall_target_mm <= 16'd1000;
    end else if (cfg_we) begin
      case (pscm_pkg::cfg_idx_t'(cfg_index))
        pscm_pkg::CFG_TURN_FRAMES: cfg.turn_frames    <= cfg_data;
        pscm_pkg::CFG_FRONT_CLEAR: cfg.front_clear_mm <= cfg_data;
        pscm_pkg::CFG_NEAR_WALL:   cfg.near_wall_mm   <= cfg_data;
        pscm_pkg::CFG_REOPEN:      cfg.reopen_mm      <= cfg_data;
        pscm_pkg::CFG_FOOT_BACK:   cfg.foot_back_mm   <= cfg_data;
        pscm_pkg::CFG_FOOT_STOP:   cfg.foot_stop_mm   <= cfg_data;
        pscm_pkg::CFG_SIDE_LIMIT:  cfg.side_limit_mm  <= cfg_data;
        pscm_pkg::CFG_WALL_TARGET: cfg.wall_target_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_ready) begin
      frame_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame.front_mm     <= front_mm & DIST_MASK;
      frame.foot_mm      <= foot_mm & DIST_MASK;
      frame.side_a_mm    <= side_a_mm & DIST_MASK;
      frame.side_b_mm    <= side_b_mm & DIST_MASK;
      frame.person_seen  <= person_seen;
      frame.pose_turn    <= pose_turn;
      frame.friend_color <= friend_color;
    end
  end

  pscm_step u_step (
    .cfg   (cfg),
    .frame (frame),
    .st    (st),
    .nx    (st_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.frame_count    <= '0;
      st.turn_start     <= '0;
      st.patrol_turning <= 1'b0;
      st.uturn_phase    <= pscm_pkg::PH_IDLE;
      st.lost_rearm     <= 1'b1;
      st.gesture_turn   <= pscm_pkg::GEST_NONE;
      st.steer_hold     <= pscm_pkg::STEER_ZERO;
      st.speed_hold     <= pscm_pkg::SPEED_STOP;
    end else if (frame_adv) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_adv) begin
      steer_cmd <= st_next.steer_hold;
      speed_cmd <= st_next.speed_hold;
    end
  end

endmodule

// File: rtl/core/pscm_step.sv
// per-frame mode decision: next controller state and command from one sensor frame
module pscm_step (
  input  pscm_pkg::cfg_t   cfg,
  input  pscm_pkg::frame_t frame,
  input  pscm_pkg::state_t st,
  output pscm_pkg::state_t nx
);

  logic [pscm_pkg::FRAME_W-1:0]                  fc_next;
  logic [pscm_pkg::FRAME_W-1:0]                  elapsed;
  logic signed [pscm_pkg::DIST_W:0]              diff;
  logic [pscm_pkg::DIST_W:0]                     mag;
  logic [pscm_pkg::DIST_W+pscm_pkg::GAIN_W-1:0]  prod;
  logic [pscm_pkg::GAIN_W-1:0]                   quot;
  logic signed [pscm_pkg::STEER_W-1:0]           wall_steer;
  logic                                          gest_active;
  logic                                          pose_valid;
  logic                                          patrol;
  logic                                          finish;
  pscm_pkg::phase_t                              ph;

  assign fc_next = st.frame_count + 32'd1;
  assign elapsed = fc_next - st.turn_start;

  // proportional wall steering, truncated toward zero
  assign diff = $signed({1'b0, frame.side_a_mm}) - $signed({1'b0, cfg.wall_target_mm});
  assign mag  = diff[pscm_pkg::DIST_W] ? 17'(-diff) : 17'(diff);
  assign prod = mag[pscm_pkg::DIST_W-1:0] * pscm_pkg::STEER_GAIN;
  assign quot = prod[pscm_pkg::DIST_W+pscm_pkg::GAIN_W-1:pscm_pkg::DIST_W];
  assign wall_steer = diff[pscm_pkg::DIST_W] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  assign gest_active = (st.gesture_turn == pscm_pkg::GEST_LEFT) ||
                       (st.gesture_turn == pscm_pkg::GEST_RIGHT);
  assign pose_valid  = (frame.pose_turn == 2'(pscm_pkg::GEST_LEFT)) ||
                       (frame.pose_turn == 2'(pscm_pkg::GEST_RIGHT));
  assign finish = (frame.front_mm >= cfg.reopen_mm) &&
                  (frame.side_b_mm <= cfg.side_limit_mm) &&
                  (frame.side_a_mm <= cfg.side_limit_mm);

  always_comb begin
    nx = st;
    nx.frame_count = fc_next;
    patrol = 1'b1;
    ph = pscm_pkg::PH_FWD;

    if (gest_active) begin
      if (elapsed < {16'd0, cfg.turn_frames}) begin
        nx.steer_hold = (st.gesture_turn == pscm_pkg::GEST_LEFT) ?
                        pscm_pkg::STEER_GEST_LEFT : pscm_pkg::STEER_GEST_RIGHT;
        nx.speed_hold = pscm_pkg::SPEED_TURN;
      end else begin
        nx.gesture_turn = pscm_pkg::GEST_NONE;
        nx.steer_hold = pscm_pkg::STEER_NUDGE;
      end
      patrol = 1'b0;
    end else if (frame.person_seen) begin
      nx.lost_rearm = 1'b1;
      if (frame.friend_color && pose_valid) begin
        nx.uturn_phase = pscm_pkg::PH_IDLE;
        nx.gesture_turn = pscm_pkg::gesture_t'(frame.pose_turn);
        nx.turn_start = fc_next;
      end else begin
        if (frame.foot_mm < cfg.foot_back_mm) begin
          nx.steer_hold = pscm_pkg::STEER_NUDGE;
          nx.speed_hold = pscm_pkg::SPEED_BACK;
        end else if (frame.foot_mm < cfg.foot_stop_mm) begin
          nx.steer_hold = pscm_pkg::STEER_ZERO;
          nx.speed_hold = pscm_pkg::SPEED_STOP;
        end else begin
          nx.steer_hold = wall_steer;
          nx.speed_hold = pscm_pkg::SPEED_FWD;
        end
        patrol = 1'b0;
      end
    end else begin
      if (st.lost_rearm) begin
        nx.turn_start = fc_next;
        nx.lost_rearm = 1'b0;
      end
      nx.patrol_turning = !(frame.front_mm > cfg.front_clear_mm);
    end

    if (patrol) begin
      if (!nx.patrol_turning) begin
        nx.steer_hold = wall_steer;
        nx.speed_hold = pscm_pkg::SPEED_FWD;
      end else begin
        ph = (nx.uturn_phase == pscm_pkg::PH_IDLE) ? pscm_pkg::PH_FWD : nx.uturn_phase;
        nx.uturn_phase = ph;
        case (ph)
          pscm_pkg::PH_FWD: begin
            nx.steer_hold = pscm_pkg::STEER_UTURN_FWD;
            nx.speed_hold = pscm_pkg::SPEED_TURN;
            if (frame.front_mm <= cfg.near_wall_mm) nx.uturn_phase = pscm_pkg::PH_REV;
          end
          pscm_pkg::PH_REV: begin
            nx.steer_hold = pscm_pkg::STEER_UTURN_REV;
            nx.speed_hold = pscm_pkg::SPEED_BACK;
            if (frame.front_mm >= cfg.reopen_mm) nx.uturn_phase = pscm_pkg::PH_FINAL;
          end
          default: begin
            nx.steer_hold = pscm_pkg::STEER_UTURN_FWD;
            nx.speed_hold = pscm_pkg::SPEED_FINAL;
            if (frame.front_mm <= cfg.near_wall_mm) nx.uturn_phase = pscm_pkg::PH_REV;
            if (finish) begin
              nx.patrol_turning = 1'b0;
              nx.uturn_phase = pscm_pkg::PH_IDLE;
              nx.steer_hold = pscm_pkg::STEER_FINISH;
              nx.speed_hold = pscm_pkg::SPEED_FWD;
              nx.lost_rearm = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/core/pscm_checker.sv
// port-level checks for the patrol steering mode controller, bound to the top level
module pscm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pscm_pkg::STEER_W-1:0] steer_cmd,
  input logic signed [pscm_pkg::SPEED_W-1:0] speed_cmd
);

  // speed command never leaves the range -SPEED_MAX to SPEED_MAX
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_cmd <= pscm_pkg::SPEED_MAX && speed_cmd >= -pscm_pkg::SPEED_MAX))
    else $error("speed command out of range");

  // a stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(steer_cmd) && $stable(speed_cmd))
    else $error("stalled command changed");

  // no command straight after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("command valid after reset");

  // an accepted transaction reaches the output register when the output is free
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted frame gave no command");

  // input is taken whenever the output side is draining
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with free output");

endmodule

bind patrol_steering_mode_controller_unit pscm_checker u_pscm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .steer_cmd (steer_cmd),
  .speed_cmd (speed_cmd)
);
